/* rtl/bmaf_pkg.sv */
// Shared types and constants of the BLE manufacturer advertising data filter.
// No dependencies; used by every module of the block.
`default_nettype none

package bmaf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned CompW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] AdTypeManuf   = 8'hFF;
  localparam logic [ByteW-1:0] MinManufLen   = 8'd4;
  localparam logic [ByteW-1:0] ManufHdrBytes = 8'd3;
  localparam logic [ByteW-1:0] PayloadOffset = 8'd4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RECEIVE_ENABLE = 2'd0,
    CFG_RSSI_MINIMUM   = 2'd1,
    CFG_OWN_ADDRESS    = 2'd2,
    CFG_COMPANY_ID     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              receive_enable;
    logic [ByteW-1:0]  rssi_minimum;
    logic [AddrW-1:0]  own_address;
    logic [CompW-1:0]  company_id;
  } cfg_t;

  typedef struct packed {
    logic             last_of_payload;
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] payload_byte;
  } res_t;

endpackage

`default_nettype wire

/* rtl/bmaf_parser.sv */
// AD structure walker: holds the parse state and forms at most one result per request.
// Depends on bmaf_pkg.
`default_nettype none

module bmaf_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bmaf_pkg::cfg_t    cfg,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              start_of_report,
  input  wire logic [7:0]        report_length,
  input  wire logic [7:0]        signal_strength,
  input  wire logic [47:0]       sender_address,
  output logic                   res_valid,
  output bmaf_pkg::res_t         res
);
  import bmaf_pkg::*;

  logic [ByteW-1:0] left_r, left_nxt;
  logic [ByteW-1:0] off_r, off_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] type_r, type_nxt;
  logic [ByteW-1:0] low_r, low_nxt;
  logic             match_r, match_nxt;
  logic             stop_r, stop_nxt;

  logic [ByteW-1:0] e_left, e_off, e_len, e_type, e_low;
  logic             e_match, e_stop, drop;
  logic [ByteW:0]   need;

  always_comb begin
    drop = !cfg.receive_enable ||
           ($signed(signal_strength) < $signed(cfg.rssi_minimum)) ||
           (sender_address == cfg.own_address);
    // A start restarts the walk from a clean state before this byte is parsed
    if (start_of_report) begin
      e_left  = report_length;
      e_off   = '0;
      e_len   = '0;
      e_type  = '0;
      e_low   = '0;
      e_match = 1'b0;
      e_stop  = drop;
    end else begin
      e_left  = left_r;
      e_off   = off_r;
      e_len   = len_r;
      e_type  = type_r;
      e_low   = low_r;
      e_match = match_r;
      e_stop  = stop_r;
    end

    left_nxt  = e_left;
    off_nxt   = e_off;
    len_nxt   = e_len;
    type_nxt  = e_type;
    low_nxt   = e_low;
    match_nxt = e_match;
    stop_nxt  = e_stop;
    res_valid = 1'b0;
    res.payload_byte    = data_byte;
    res.payload_length  = e_len - ManufHdrBytes;
    res.last_of_payload = (e_off == e_len);
    need = {1'b0, data_byte} + {{ByteW{1'b0}}, 1'b1};

    if (!e_stop) begin
      if (e_off == '0) begin
        // Length byte: stop on short report, zero length or overrun
        if (e_left <= 8'd1 || data_byte == '0 || need > {1'b0, e_left}) begin
          stop_nxt = 1'b1;
        end else begin
          len_nxt   = data_byte;
          match_nxt = 1'b0;
          off_nxt   = 8'd1;
          left_nxt  = e_left - 8'd1;
        end
      end else begin
        priority if (e_off == 8'd1) begin
          type_nxt = data_byte;
        end else if (e_off == 8'd2) begin
          low_nxt = data_byte;
        end else if (e_off == 8'd3) begin
          if (e_type == AdTypeManuf && e_len >= MinManufLen &&
              {data_byte, e_low} == cfg.company_id) begin
            match_nxt = 1'b1;
          end
        end else if (e_match && e_off >= PayloadOffset) begin
          res_valid = accept;
          if (res.last_of_payload) begin
            stop_nxt = 1'b1;
          end
        end else begin
          stop_nxt = e_stop;
        end
        off_nxt = (e_off >= e_len) ? '0 : e_off + 8'd1;
        if (e_left != '0) begin
          left_nxt = e_left - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      off_r   <= '0;
      len_r   <= '0;
      type_r  <= '0;
      low_r   <= '0;
      match_r <= 1'b0;
      stop_r  <= 1'b1;
    end else if (accept) begin
      left_r  <= left_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      low_r   <= low_nxt;
      match_r <= match_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/bmaf_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
// Depends on bmaf_pkg.
`default_nettype none

module bmaf_out_buf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bmaf_pkg::res_t  push_data,
  output logic                 can_accept,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bmaf_pkg::res_t       out_data
);
  import bmaf_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;
  logic pop;

  assign pop        = out_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      // Output slot frees up: drain the skid first
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/ble_manufacturer_ad_filter_unit.sv */
// A result is registered in the output buffer before it appears on out_*.
// Throughput: one request per cycle while in_tready is high; state updates on accept.
// A two-entry output buffer keeps in_tready high while one result waits.
// Reset (rst_n low, synchronous): buffer empty, parser idle until a report start,
// registers at receive off, minimum RSSI -128, own address 0, company ID 0xFFFF.
// Depends on bmaf_pkg, bmaf_parser and bmaf_out_buf.
`default_nettype none

module ble_manufacturer_ad_filter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] data_byte, [15:8] report_length, [23:16] signal_strength,
  // [71:24] sender_address
  input  wire logic [71:0] in_tdata,
  // [0] start_of_report
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] payload_byte, [15:8] payload_length
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata
);
  import bmaf_pkg::*;

  cfg_t cfg_r;
  logic accept, res_valid;
  res_t res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.receive_enable <= 1'b0;
      cfg_r.rssi_minimum   <= 8'h80;
      cfg_r.own_address    <= '0;
      cfg_r.company_id     <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RECEIVE_ENABLE: cfg_r.receive_enable <= cfg_wdata[0];
        CFG_RSSI_MINIMUM:   cfg_r.rssi_minimum   <= cfg_wdata[ByteW-1:0];
        CFG_OWN_ADDRESS:    cfg_r.own_address    <= cfg_wdata[AddrW-1:0];
        CFG_COMPANY_ID:     cfg_r.company_id     <= cfg_wdata[CompW-1:0];
        default:            cfg_r.company_id     <= cfg_r.company_id;
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;

  bmaf_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .accept          (accept),
    .data_byte       (in_tdata[7:0]),
    .start_of_report (in_tuser),
    .report_length   (in_tdata[15:8]),
    .signal_strength (in_tdata[23:16]),
    .sender_address  (in_tdata[71:24]),
    .res_valid       (res_valid),
    .res             (res)
  );

  bmaf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {out_res.payload_length, out_res.payload_byte};
  assign out_tlast = out_res.last_of_payload;

  // A full buffer implies the output register holds a result
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("skid holds a result while the output register is empty");

  // A start request with receiving disabled must never produce a result
  a_disabled_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser && !cfg_r.receive_enable) |-> !res_valid)
    else $error("result produced for a report while receiving is disabled");

  // Results are only ever pushed on an accepted request
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> accept)
    else $error("result pushed without an accepted request");

  // Every delivered payload carries a nonzero payload length
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:8] != 8'd0))
    else $error("payload length of zero on a delivered result");

endmodule

`default_nettype wire

/* verif/ble_manufacturer_ad_filter_unit_test.sv */
// Self-checking testbench for ble_manufacturer_ad_filter_unit: drives advertising
// reports on the in_ stream, predicts the manufacturer payload bytes and checks out_.
// Depends on bmaf_pkg and the RTL of the filter unit only.
module ble_manufacturer_ad_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bmaf_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam logic [47:0] OwnDirected = 48'hA1B2_C3D4_E5F6;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [7:0] data_byte, [15:8] report_length, [23:16] signal_strength,
  // [71:24] sender_address
  logic [71:0] in_tdata = '0;
  // [0] start_of_report
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] payload_byte, [15:8] payload_length
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  ble_manufacturer_ad_filter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Filter settings as the block holds them
  logic              rx_en    = 1'b0;
  logic signed [7:0] rssi_min = 8'sh80;
  logic [47:0]       own_addr = '0;
  logic [15:0]       comp_id  = 16'hFFFF;

  // Parser state of the predictor
  logic [7:0] left_cnt = '0;
  logic [7:0] offs     = '0;
  logic [7:0] slen     = '0;
  logic [7:0] stype    = '0;
  logic [7:0] comp_lo  = '0;
  logic       match_on = 1'b0;
  logic       halted   = 1'b1;

  res_t        payload_q[$];
  logic [7:0]  report_bytes[$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned reports_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_applied = 0;
  int unsigned burst_left = 0;
  logic        quiet_sender = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk one accepted request through the parser and queue any payload byte it yields.
  task automatic filter_byte(input logic [7:0] b, input logic sop, input logic [7:0] len,
                             input logic signed [7:0] rssi, input logic [47:0] addr);
    res_t want;
    if (sop) begin
      offs = '0;
      slen = '0;
      stype = '0;
      comp_lo = '0;
      match_on = 1'b0;
      left_cnt = len;
      if (!rx_en || rssi < rssi_min || addr == own_addr) begin
        halted = 1'b1;
        return;
      end
      halted = 1'b0;
    end
    if (halted) return;
    if (offs == 8'd0) begin
      // Length byte: stop on short remainder, zero length or overrun of the report
      if (left_cnt <= 8'd1 || b == 8'd0 || ({1'b0, b} + 9'd1 > {1'b0, left_cnt})) begin
        halted = 1'b1;
        return;
      end
      slen = b;
      match_on = 1'b0;
      offs = 8'd1;
      left_cnt = left_cnt - 8'd1;
      return;
    end
    if (offs == 8'd1) begin
      stype = b;
    end else if (offs == 8'd2) begin
      comp_lo = b;
    end else if (offs == 8'd3) begin
      if (stype == AdTypeManuf && slen >= MinManufLen && {b, comp_lo} == comp_id)
        match_on = 1'b1;
    end else if (match_on) begin
      want.payload_byte    = b;
      want.payload_length  = slen - ManufHdrBytes;
      want.last_of_payload = (offs == slen);
      payload_q.push_back(want);
      if (offs == slen) halted = 1'b1;
    end
    if (offs >= slen) offs = 8'd0;
    else offs = offs + 8'd1;
    if (left_cnt != 8'd0) left_cnt = left_cnt - 8'd1;
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sop, input logic [7:0] len,
                           input logic signed [7:0] rssi, input logic [47:0] addr);
    logic [63:0] noise;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    noise = {$urandom(), $urandom()};
    in_tvalid <= 1'b1;
    in_tuser  <= sop;
    // Header fields matter only on a start request; scramble them elsewhere
    if (sop) in_tdata <= {addr, rssi, len, b};
    else in_tdata <= {noise, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sop) filter_byte(b, sop, len, rssi, addr);
    else filter_byte(b, sop, noise[7:0], noise[15:8], noise[63:16]);
    items_sent++;
  endtask

  task automatic play_report(input logic [7:0] len, input logic signed [7:0] rssi,
                             input logic [47:0] addr);
    foreach (report_bytes[i]) send_byte(report_bytes[i], i == 0, len, rssi, addr);
    reports_sent++;
  endtask

  // Hold the sender until every predicted payload byte has come out.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (payload_q.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_filter(input logic rx, input logic signed [7:0] rmin,
                            input logic [47:0] own, input logic [15:0] cid);
    cfg_idx_t idx;
    logic [47:0] value;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_t'(i);
      case (idx)
        CFG_RECEIVE_ENABLE: value = {47'd0, rx};
        CFG_RSSI_MINIMUM:   value = {40'd0, rmin};
        CFG_OWN_ADDRESS:    value = own;
        CFG_COMPANY_ID:     value = {32'd0, cid};
        default:            value = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= value;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    rx_en = rx;
    rssi_min = rmin;
    own_addr = own;
    comp_id = cid;
    settings_applied++;
  endtask

  // Fill report_bytes with AD structures of random content, a share of them broken.
  task automatic build_body(input int len);
    int room;
    int cap;
    int roll;
    int fill;
    logic [15:0] id;
    report_bytes.delete();
    while (report_bytes.size() < len) begin
      room = len - report_bytes.size();
      roll = $urandom_range(0, 99);
      fill = 0;
      if (room == 1) begin
        report_bytes.push_back(8'($urandom()));
      end else if (roll < 4) begin
        report_bytes.push_back(8'd0);
        fill = room - 1;
      end else if (roll < 8) begin
        report_bytes.push_back(8'($urandom_range(room, 255)));
        fill = room - 1;
      end else begin
        cap = (room - 1 > 12 && $urandom_range(0, 3) != 0) ? 12 : room - 1;
        slen = 8'($urandom_range(1, cap));
        report_bytes.push_back(slen);
        fill = slen;
        if (roll < 60 && slen >= 8'd3) begin
          id = ($urandom_range(0, 3) != 0) ? comp_id : 16'($urandom());
          report_bytes.push_back(AdTypeManuf);
          report_bytes.push_back(id[7:0]);
          report_bytes.push_back(id[15:8]);
          fill = slen - 3;
        end
      end
      repeat (fill) report_bytes.push_back(8'($urandom()));
    end
  endtask

  task automatic random_report();
    logic [7:0]        len;
    logic signed [7:0] rssi;
    logic [47:0]       addr;
    logic [63:0]       wide;
    logic [7:0]        junk;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) len = 8'($urandom_range(1, 40));
    else if (roll < 95) len = 8'($urandom_range(41, 127));
    else len = 8'($urandom_range(128, 255));
    // build_body borrows slen as scratch; the predictor state is restored below
    junk = slen;
    build_body(len);
    slen = junk;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 3)) report_bytes.push_back(8'($urandom()));
    end else if (roll < 18 && report_bytes.size() > 1) begin
      repeat ($urandom_range(1, report_bytes.size() - 1)) junk = report_bytes.pop_back();
    end
    if ($urandom_range(0, 99) < 15) rssi = 8'($urandom());
    else rssi = 8'($urandom_range(int'(rssi_min) + 128, 255) - 128);
    wide = {$urandom(), $urandom()};
    addr = ($urandom_range(0, 9) == 0) ? own_addr : wide[47:0];
    play_report(len, rssi, addr);
    // Occasional stray requests with no start in front
    if ($urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom()), 1'b0, '0, '0, '0);
  endtask

  // Receiving stays off after reset: a report that would match the default ID is dropped.
  task automatic test_reset_state();
    report_bytes = '{8'h04, 8'hFF, 8'hFF, 8'hFF, 8'h42};
    play_report(8'd5, 8'sd127, 48'h0000_0000_0001);
    drain();
  endtask

  task automatic test_directed_reports();
    set_filter(1'b1, 8'sh80, OwnDirected, 16'h1234);
    // Match with extreme payload bytes
    report_bytes = '{8'h05, 8'hFF, 8'h34, 8'h12, 8'hFF, 8'h00};
    play_report(8'd6, 8'sh80, 48'hFFFF_FFFF_FFFF);
    // Zero structure length
    report_bytes = '{8'h00};
    play_report(8'd2, 8'sd127, 48'h0);
    // Structure running past the report end
    report_bytes = '{8'h05, 8'hFF};
    play_report(8'd3, 8'sd0, 48'h1);
    // One byte left at a structure start
    report_bytes = '{8'h01};
    play_report(8'd1, 8'sd5, 48'h2);
    // Report length zero
    report_bytes = '{8'h02, 8'hFF};
    play_report(8'd0, 8'sd5, 48'h3);
    // Own address drops an otherwise matching report
    report_bytes = '{8'h04, 8'hFF, 8'h34, 8'h12, 8'h77};
    play_report(8'd5, 8'sd10, OwnDirected);
    // Cut short by a new start in the middle of the payload
    report_bytes = '{8'h07, 8'hFF, 8'h34, 8'h12, 8'hA1, 8'hA2};
    play_report(8'd8, 8'sd10, 48'h5555_AAAA_5555);
    // Swapped ID misses, the next structure matches, trailing bytes are dropped
    report_bytes = '{8'h04, 8'hFF, 8'h12, 8'h34, 8'h01,
                     8'h04, 8'hFF, 8'h34, 8'h12, 8'h5A, 8'h99};
    play_report(8'd10, 8'sd10, 48'hAAAA_5555_AAAA);
    drain();
  endtask

  task automatic test_random_reports();
    logic [63:0] wide;
    int unsigned target;
    for (int p = 0; p < 6; p++) begin
      drain();
      wide = {$urandom(), $urandom()};
      case (p)
        0: set_filter(1'b1, 8'sh80, wide[47:0], 16'($urandom()));
        1: set_filter(1'b1, 8'sh7F, wide[47:0], 16'h0000);
        2: set_filter(1'b1, 8'($urandom()), 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        3: set_filter(1'b1, 8'sd0, 48'h0, 16'($urandom()));
        4: set_filter(1'b0, 8'($urandom()), wide[47:0], 16'($urandom()));
        default: set_filter(1'b1, -8'sd1, wide[47:0], 16'($urandom()));
      endcase
      quiet_sender = (p == 2);
      target = items_sent + ((p == 4) ? 80 : 360);
      while (items_sent < target) begin
        random_report();
        if ($urandom_range(0, 15) == 0) wait_for_results();
      end
      wait_for_results();
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_reports();
    test_random_reports();
    drain();
    $display("Sent %0d requests in %0d reports under %0d filter settings; %0d payload bytes checked.",
             items_sent, reports_sent, settings_applied + 1, results_seen);
    if (errors == 0) begin
      $display("ble_manufacturer_ad_filter_unit_test: clean");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("ble_manufacturer_ad_filter_unit_test: errors");
    end
    $finish;
  end

  // Receiver backpressure: stall rate changes on its own schedule
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(32, 400);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end else begin
      stall_left--;
    end
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (payload_q.size() == 0) begin
        flag_error($sformatf("payload byte %02h with nothing pending", out_tdata[7:0]));
      end else begin
        want = payload_q.pop_front();
        if (out_tdata[7:0] !== want.payload_byte)
          flag_error($sformatf("payload_byte exp %02h got %02h",
                               want.payload_byte, out_tdata[7:0]));
        if (out_tdata[15:8] !== want.payload_length)
          flag_error($sformatf("payload_length exp %0d got %0d",
                               want.payload_length, out_tdata[15:8]));
        if (out_tlast !== want.last_of_payload)
          flag_error($sformatf("last_of_payload exp %b got %b",
                               want.last_of_payload, out_tlast));
      end
    end
  end

  // Watchdog: end the run when no request, result or config write moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("Timeout: no request moved for %0d cycles, %0d results pending",
               StallLimit, payload_q.size());
      $display("ble_manufacturer_ad_filter_unit_test: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

/* sim.f */
rtl/bmaf_pkg.sv
rtl/bmaf_parser.sv
rtl/bmaf_out_buf.sv
rtl/ble_manufacturer_ad_filter_unit.sv
verif/ble_manufacturer_ad_filter_unit_test.sv
